### src/spline_surface_height_macros.svh
// assertion macros of the surface height block
// no dependencies; included by the top module, which carries the assertions
`ifndef SPLINE_SURFACE_HEIGHT_MACROS_SVH
`define SPLINE_SURFACE_HEIGHT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SSH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
// next-cycle implication
`define SSH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SSH_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SSH_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### src/ssh_pkg.sv
// shared constants, types and state encodings of the surface height block
// no dependencies
`default_nettype none
package ssh_pkg;

    localparam int MAX_POINTS = 16;
    localparam int PTR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int NUM_LANES  = 3;

    localparam int NOISE_W    = 16;
    localparam int HEIGHT_W   = 24;
    localparam int STR_W      = 16;
    localparam int SEA_W      = 12;
    localparam int BWS_W      = 16;
    localparam int COL_W      = 11;
    localparam int HI_W       = 10;
    localparam int SH_W       = 10;
    localparam int FINE_W     = 18;
    localparam int T_W        = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STR_CONT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STR_PEAKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STR_EROS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEA       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BWS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COL       = 3'd5;

    // opcodes and curve selects
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam logic [1:0] CURVE_CONT  = 2'd0;
    localparam logic [1:0] CURVE_PEAKS = 2'd1;
    localparam logic [1:0] CURVE_EROS  = 2'd2;

    typedef struct packed {
        logic [NOISE_W-1:0]  noise;
        logic [HEIGHT_W-1:0] height;
    } point_t;

    typedef struct packed {
        logic             we;
        logic             last;
        logic [PTR_W-1:0] addr;
        point_t           pt;
    } lane_wr_t;

    typedef struct packed {
        logic                done;
        logic [HEIGHT_W-1:0] height;
    } lane_stat_t;

    typedef struct packed {
        logic [NUM_LANES-1:0][STR_W-1:0] strength;
        logic [SEA_W-1:0]                sea;
        logic [BWS_W-1:0]                bws;
        logic [HI_W-1:0]                 hi;
    } comb_cfg_t;

    typedef struct packed {
        logic              done;
        logic [SH_W-1:0]   surface;
        logic [FINE_W-1:0] fine;
    } comb_res_t;

    typedef enum logic [2:0] {L_IDLE, L_SCAN, L_DIV, L_MUL, L_SUM} lane_state_t;
    typedef enum logic [2:0] {C_IDLE, C_MAC, C_DEN, C_DIV, C_CLAMP} comb_state_t;
    typedef enum logic [1:0] {T_IDLE, T_LANES, T_COMB} top_state_t;

endpackage
`default_nettype wire

### src/spline_surface_height.sv
// Surface height block, top level: registers, load routing, query control, output stage.
// Load transfers (opcode 0) write one breakpoint into the selected curve table; a point
// marked last sets that table's count. Query transfers (opcode 1) run the three curve
// lanes side by side, then the merging stage, and give one result.
// Configuration is written through cfg_wen/cfg_index/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// A query runs the lane scan and, for an inner segment, the fraction divider and the
// multiply and sum steps; once all lanes are done, the merging stage runs its mac,
// divisor, serial divider, clamp and hand-off steps (mac and divisor are skipped when
// all strengths are zero, the divider when the weighted sum is not positive).
// One item is in work at a time; s_ready is high only between items. Loads leave
// s_ready high, so loads can follow one another back to back.
// The result sits in an output register; the next item is taken while it waits.
// When m_ready is low, the following result waits in the merging stage.
// Reset clears counts (tables read as empty), registers to their defaults, valid flags.
// Depends on ssh_pkg, ssh_lane, ssh_combine and spline_surface_height_macros.svh.
`default_nettype none
`include "spline_surface_height_macros.svh"
module spline_surface_height (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wen,
    input  wire logic [ssh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ssh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_opcode,
    input  wire logic [1:0]                        s_curve_select,
    input  wire logic [3:0]                        s_point_index,
    input  wire logic                              s_point_last,
    input  wire logic signed [ssh_pkg::NOISE_W-1:0]  s_point_noise,
    input  wire logic signed [ssh_pkg::HEIGHT_W-1:0] s_point_height,
    input  wire logic signed [ssh_pkg::NOISE_W-1:0]  s_continental_value,
    input  wire logic signed [ssh_pkg::NOISE_W-1:0]  s_peaks_value,
    input  wire logic signed [ssh_pkg::NOISE_W-1:0]  s_erosion_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [ssh_pkg::SH_W-1:0]               m_surface_height,
    output logic [ssh_pkg::FINE_W-1:0]             m_surface_height_fine
);
    import ssh_pkg::*;

    logic [STR_W-1:0]  str_cont_reg, str_peaks_reg, str_eros_reg;
    logic [SEA_W-1:0]  sea_reg;
    logic [BWS_W-1:0]  bws_reg;
    logic [COL_W-1:0]  col_reg;

    top_state_t        state_reg, state_next;
    logic [NUM_LANES-1:0][NOISE_W-1:0] value_reg, value_next;
    logic              m_valid_reg, m_valid_next;
    logic [SH_W-1:0]   m_surf_reg, m_surf_next;
    logic [FINE_W-1:0] m_fine_reg, m_fine_next;

    logic              in_xfer, load_ok, lanes_start, comb_start, all_done, out_free;
    logic [HI_W-1:0]   hi;
    lane_wr_t          lane_wr [NUM_LANES];
    lane_stat_t        lane_stat [NUM_LANES];
    logic [NUM_LANES-1:0][HEIGHT_W-1:0] heights;
    logic [NUM_LANES-1:0] done_vec;
    comb_cfg_t         comb_cfg;
    comb_res_t         comb_res;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            str_cont_reg  <= STR_W'(256);
            str_peaks_reg <= STR_W'(256);
            str_eros_reg  <= STR_W'(256);
            sea_reg       <= SEA_W'(64);
            bws_reg       <= BWS_W'(256);
            col_reg       <= COL_W'(256);
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_STR_CONT:  str_cont_reg  <= cfg_wdata[STR_W-1:0];
                CFG_STR_PEAKS: str_peaks_reg <= cfg_wdata[STR_W-1:0];
                CFG_STR_EROS:  str_eros_reg  <= cfg_wdata[STR_W-1:0];
                CFG_SEA:       sea_reg       <= cfg_wdata[SEA_W-1:0];
                CFG_BWS:       bws_reg       <= cfg_wdata[BWS_W-1:0];
                CFG_COL:       col_reg       <= cfg_wdata[COL_W-1:0];
                default: ;
            endcase
        end
    end

    // upper bound: column height saturated to 9..1024, minus 8
    always_comb begin
        if (col_reg < COL_W'(9)) begin
            hi = HI_W'(1);
        end else if (col_reg > COL_W'(1024)) begin
            hi = HI_W'(1016);
        end else begin
            hi = HI_W'(col_reg - COL_W'(8));
        end
    end

    assign s_ready = (state_reg == T_IDLE);
    assign in_xfer = s_valid && s_ready;
    assign load_ok = in_xfer && (s_opcode == OP_LOAD)
                   && ({1'b0, s_point_index} < 5'(MAX_POINTS));

    // load routing to the lanes
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_wr[i].we        = load_ok && (s_curve_select == 2'(i));
            lane_wr[i].last      = s_point_last;
            lane_wr[i].addr      = PTR_W'(s_point_index);
            lane_wr[i].pt.noise  = s_point_noise;
            lane_wr[i].pt.height = s_point_height;
        end
    end

    assign lanes_start = in_xfer && (s_opcode == OP_QUERY);

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        ssh_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr      (lane_wr[g]),
            .start   (lanes_start),
            .value   (value_reg[g]),
            .stat    (lane_stat[g])
        );
        assign heights[g]  = lane_stat[g].height;
        assign done_vec[g] = lane_stat[g].done;
    end

    assign all_done = &done_vec;
    assign comb_start = (state_reg == T_LANES) && all_done;

    assign comb_cfg.strength[CURVE_CONT]  = str_cont_reg;
    assign comb_cfg.strength[CURVE_PEAKS] = str_peaks_reg;
    assign comb_cfg.strength[CURVE_EROS]  = str_eros_reg;
    assign comb_cfg.sea = sea_reg;
    assign comb_cfg.bws = bws_reg;
    assign comb_cfg.hi  = hi;

    ssh_combine u_combine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (comb_start),
        .heights (heights),
        .cfg     (comb_cfg),
        .res     (comb_res)
    );

    // state and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        m_surf_reg <= m_surf_next;
        m_fine_reg <= m_fine_next;
    end

    assign out_free = !m_valid_reg || m_ready;

    // query control and output transfer
    always_comb begin
        state_next   = state_reg;
        value_next   = value_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_surf_next  = m_surf_reg;
        m_fine_next  = m_fine_reg;
        case (state_reg)
            T_IDLE: begin
                if (lanes_start) begin
                    value_next[CURVE_CONT]  = s_continental_value;
                    value_next[CURVE_PEAKS] = s_peaks_value;
                    value_next[CURVE_EROS]  = s_erosion_value;
                    state_next = T_LANES;
                end
            end
            T_LANES: begin
                if (all_done) begin
                    state_next = T_COMB;
                end
            end
            T_COMB: begin
                if (comb_res.done && out_free) begin
                    m_valid_next = 1'b1;
                    m_surf_next  = comb_res.surface;
                    m_fine_next  = comb_res.fine;
                    state_next   = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    assign m_valid               = m_valid_reg;
    assign m_surface_height      = m_surf_reg;
    assign m_surface_height_fine = m_fine_reg;

    // checks
    `SSH_ASSERT_NXT(a_query_starts_lanes, aclk, aresetn, lanes_start, state_reg == T_LANES)
    `SSH_ASSERT_IMP(a_fine_in_range, aclk, aresetn, state_reg == T_COMB && comb_res.done, comb_res.fine >= FINE_W'(256) && comb_res.fine <= {hi, 8'd0})
    `SSH_ASSERT_IMP(a_out_in_range, aclk, aresetn, m_valid_reg, m_surf_reg >= SH_W'(1) && m_surf_reg <= hi)

endmodule
`default_nettype wire

### src/ssh_lane.sv
// one curve lane: breakpoint table, segment scan, fraction divider, interpolation
// depends on ssh_pkg
`default_nettype none
module ssh_lane (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ssh_pkg::lane_wr_t             wr,
    input  wire logic                          start,
    input  wire logic [ssh_pkg::NOISE_W-1:0]   value,
    output ssh_pkg::lane_stat_t                stat
);
    import ssh_pkg::*;

    point_t              table_mem [MAX_POINTS];
    point_t              rd_data_reg;
    lane_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [PTR_W-1:0]    addr_reg, addr_next;
    logic                dvalid_reg, dvalid_next;
    logic [PTR_W-1:0]    didx_reg, didx_next;
    point_t              prev_reg, prev_next;
    point_t              first_reg, first_next;
    logic [NOISE_W-1:0]  d_reg, d_next;
    logic [HEIGHT_W-1:0] h0_reg, h0_next;
    logic [HEIGHT_W:0]   dh_reg, dh_next;
    logic [T_W-1:0]      rem_reg, rem_next;
    logic [T_W-1:0]      q_reg, q_next;
    logic [4:0]          step_reg, step_next;
    logic signed [HEIGHT_W+T_W+1:0] prod_reg, prod_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic                done_reg, done_next;

    logic signed [NOISE_W:0] span, offs;
    logic [T_W-1:0]          rem_sub;
    logic                    trial;
    logic signed [HEIGHT_W+T_W+1:0] rnd, shd;
    point_t                  first_pt;
    logic [PTR_W-1:0]        last_idx;

    // table write port and registered read
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            table_mem[wr.addr] <= wr.pt;
        end
        rd_data_reg <= table_mem[addr_reg];
    end

    // point count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (wr.we && wr.last) begin
            count_reg <= CNT_W'(wr.addr) + CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= L_IDLE;
            done_reg   <= 1'b0;
            dvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            dvalid_reg <= dvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        didx_reg   <= didx_next;
        prev_reg   <= prev_next;
        first_reg  <= first_next;
        d_reg      <= d_next;
        h0_reg     <= h0_next;
        dh_reg     <= dh_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        step_reg   <= step_next;
        prod_reg   <= prod_next;
        height_reg <= height_next;
    end

    assign span     = $signed({rd_data_reg.noise[NOISE_W-1], rd_data_reg.noise})
                    - $signed({prev_reg.noise[NOISE_W-1], prev_reg.noise});
    assign offs     = $signed({value[NOISE_W-1], value})
                    - $signed({prev_reg.noise[NOISE_W-1], prev_reg.noise});
    assign trial    = rem_reg >= {1'b0, d_reg};
    assign rem_sub  = trial ? (rem_reg - {1'b0, d_reg}) : rem_reg;
    assign rnd      = prod_reg + (HEIGHT_W+T_W+2)'(32768);
    assign shd      = rnd >>> 16;
    assign first_pt = (didx_reg == '0) ? rd_data_reg : first_reg;
    assign last_idx = PTR_W'(count_reg - CNT_W'(1));

    // scan, divide and interpolate sequencer
    always_comb begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        dvalid_next = 1'b0;
        didx_next   = didx_reg;
        prev_next   = prev_reg;
        first_next  = first_reg;
        d_next      = d_reg;
        h0_next     = h0_reg;
        dh_next     = dh_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        step_next   = step_reg;
        prod_next   = prod_reg;
        height_next = height_reg;
        done_next   = done_reg;
        case (state_reg)
            L_IDLE: begin
                if (start) begin
                    done_next = 1'b0;
                    addr_next = '0;
                    if (count_reg == '0) begin
                        height_next = '0;
                        done_next   = 1'b1;
                    end else begin
                        state_next = L_SCAN;
                    end
                end
            end
            L_SCAN: begin
                addr_next   = addr_reg + PTR_W'(1);
                dvalid_next = 1'b1;
                didx_next   = addr_reg;
                if (dvalid_reg) begin
                    if (didx_reg == '0) begin
                        first_next = rd_data_reg;
                    end
                    if (didx_reg != '0
                        && $signed(prev_reg.noise) <= $signed(value)
                        && $signed(value) <= $signed(rd_data_reg.noise)) begin
                        // segment found
                        if (span == '0) begin
                            height_next = prev_reg.height;
                            done_next   = 1'b1;
                            state_next  = L_IDLE;
                        end else begin
                            d_next     = span[NOISE_W-1:0];
                            rem_next   = {1'b0, offs[NOISE_W-1:0]};
                            q_next     = '0;
                            step_next  = '0;
                            h0_next    = prev_reg.height;
                            dh_next    = {rd_data_reg.height[HEIGHT_W-1], rd_data_reg.height}
                                       - {prev_reg.height[HEIGHT_W-1], prev_reg.height};
                            state_next = L_DIV;
                        end
                    end else if (didx_reg == last_idx) begin
                        // outside every segment: end heights
                        if ($signed(value) < $signed(first_pt.noise)) begin
                            height_next = first_pt.height;
                        end else begin
                            height_next = rd_data_reg.height;
                        end
                        done_next  = 1'b1;
                        state_next = L_IDLE;
                    end else begin
                        prev_next = rd_data_reg;
                    end
                end
            end
            L_DIV: begin
                // one quotient bit per cycle of the Q1.16 fraction
                rem_next  = {rem_sub[T_W-2:0], 1'b0};
                q_next    = {q_reg[T_W-2:0], trial};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(T_W - 1)) begin
                    state_next = L_MUL;
                end
            end
            L_MUL: begin
                prod_next  = $signed(dh_reg) * $signed({1'b0, q_reg});
                state_next = L_SUM;
            end
            L_SUM: begin
                height_next = h0_reg + shd[HEIGHT_W-1:0];
                done_next   = 1'b1;
                state_next  = L_IDLE;
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase
    end

    assign stat.done   = done_reg;
    assign stat.height = height_reg;

endmodule
`default_nettype wire

### src/ssh_combine.sv
// merging stage: weighted sum of lane heights, serial divide, clamp and round
// depends on ssh_pkg
`default_nettype none
module ssh_combine (
    input  wire logic                                            aclk,
    input  wire logic                                            aresetn,
    input  wire logic                                            start,
    input  wire logic [ssh_pkg::NUM_LANES-1:0][ssh_pkg::HEIGHT_W-1:0] heights,
    input  wire ssh_pkg::comb_cfg_t                              cfg,
    output ssh_pkg::comb_res_t                                   res
);
    import ssh_pkg::*;

    localparam int ACC_W = HEIGHT_W + STR_W + 3;
    localparam int TOT_W = STR_W + 2;
    localparam int DEN_W = TOT_W + BWS_W;
    localparam int NUM_W = 50;
    localparam int STEP_W = $clog2(NUM_W);
    localparam int K_W   = $clog2(NUM_LANES);

    comb_state_t             state_reg, state_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [K_W-1:0]          k_reg, k_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [DEN_W:0]          rem_reg, rem_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [FINE_W-1:0]       fine_reg, fine_next;
    logic [SH_W-1:0]         surf_reg, surf_next;
    logic                    done_reg, done_next;

    logic [TOT_W-1:0]        tot;
    logic [BWS_W-1:0]        bws_eff;
    logic signed [HEIGHT_W+STR_W:0] mult;
    logic [DEN_W:0]          rem_sh;
    logic                    trial;
    logic [FINE_W-1:0]       hi_f;
    logic [FINE_W-1:0]       fine_c;
    logic [FINE_W-1:0]       rnd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        k_reg    <= k_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        fine_reg <= fine_next;
        surf_reg <= surf_next;
    end

    assign tot     = TOT_W'(cfg.strength[0]) + TOT_W'(cfg.strength[1])
                   + TOT_W'(cfg.strength[2]);
    assign bws_eff = (cfg.bws == '0) ? BWS_W'(1) : cfg.bws;
    assign mult    = $signed(heights[k_reg]) * $signed({1'b0, cfg.strength[k_reg]});
    assign rem_sh  = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
    assign trial   = rem_sh >= {1'b0, den_reg};
    assign hi_f    = {cfg.hi, 8'd0};

    // clamp of the quotient to 1.0 .. hi
    always_comb begin
        if (num_reg < NUM_W'(256)) begin
            fine_c = FINE_W'(256);
        end else if (num_reg > NUM_W'(hi_f)) begin
            fine_c = hi_f;
        end else begin
            fine_c = num_reg[FINE_W-1:0];
        end
    end
    // clamped value is at most 1016.0, so adding one half stays in range
    assign rnd = fine_c + FINE_W'(128);

    // mac, divide and clamp sequencer
    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        k_next     = k_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        fine_next  = fine_reg;
        surf_next  = surf_reg;
        done_next  = done_reg;
        case (state_reg)
            C_IDLE: begin
                if (start) begin
                    done_next = 1'b0;
                    rem_next  = '0;
                    step_next = '0;
                    acc_next  = '0;
                    k_next    = '0;
                    if (tot == '0) begin
                        // all strengths zero: sea level over block size
                        num_next   = NUM_W'({cfg.sea, 16'd0});
                        den_next   = DEN_W'(bws_eff);
                        state_next = C_DIV;
                    end else begin
                        state_next = C_MAC;
                    end
                end
            end
            C_MAC: begin
                acc_next = acc_reg + ACC_W'(mult);
                k_next   = k_reg + K_W'(1);
                if (k_reg == K_W'(NUM_LANES - 1)) begin
                    state_next = C_DEN;
                end
            end
            C_DEN: begin
                den_next = tot * bws_eff;
                num_next = NUM_W'({acc_reg, 8'd0});
                if (acc_reg <= 0) begin
                    // non-positive sum clamps to the floor
                    num_next   = '0;
                    state_next = C_CLAMP;
                end else begin
                    state_next = C_DIV;
                end
            end
            C_DIV: begin
                rem_next  = trial ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                num_next  = {num_reg[NUM_W-2:0], trial};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUM_W - 1)) begin
                    state_next = C_CLAMP;
                end
            end
            C_CLAMP: begin
                fine_next  = fine_c;
                surf_next  = rnd[FINE_W-1:8];
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    assign res.done    = done_reg;
    assign res.fine    = fine_reg;
    assign res.surface = surf_reg;

endmodule
`default_nettype wire

### verif/spline_surface_height_tb.sv
// self-checking testbench for spline_surface_height: breakpoint loads, height queries
// depends on ssh_pkg and the spline_surface_height rtl; carries its own height predictor
`timescale 1ns / 100ps
module spline_surface_height_tb;
    import ssh_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 150;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct {
        logic              opcode;
        logic [1:0]        curve;
        logic [3:0]        index;
        logic              last;
        logic signed [15:0] noise;
        logic signed [23:0] height;
        logic signed [15:0] cont_v;
        logic signed [15:0] peaks_v;
        logic signed [15:0] eros_v;
    } item_t;

    // tracks table contents, registers and the heights still owed by the block
    class height_scoreboard;
        longint strength[3];
        longint sea, bws, col;
        longint bp_x[3][MAX_POINTS];
        longint bp_h[3][MAX_POINTS];
        bit     bp_written[3][MAX_POINTS];
        int     bp_count[3];
        int     owed_sh[$];
        int     owed_fine[$];
        int     errors;

        function new();
            for (int c = 0; c < 3; c++) begin
                strength[c] = 256;
                bp_count[c] = 0;
                for (int i = 0; i < MAX_POINTS; i++) bp_written[c][i] = 0;
            end
            sea = 64; bws = 256; col = 256; errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_STR_CONT:  strength[0] = d;
                CFG_STR_PEAKS: strength[1] = d;
                CFG_STR_EROS:  strength[2] = d;
                CFG_SEA:       sea = d[SEA_W-1:0];
                CFG_BWS:       bws = d;
                CFG_COL:       col = d[COL_W-1:0];
                default: ;
            endcase
        endfunction

        function longint floor_div(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
            return q;
        endfunction

        // piecewise-linear lookup, first containing segment wins
        function longint curve_height(int c, longint v);
            longint x0, x1, h0, h1, t;
            int n;
            n = bp_count[c];
            if (n == 0) return 0;
            for (int i = 0; i + 1 < n; i++) begin
                x0 = bp_x[c][i]; x1 = bp_x[c][i+1];
                if (v >= x0 && v <= x1) begin
                    h0 = bp_h[c][i]; h1 = bp_h[c][i+1];
                    if (x1 == x0) return h0;
                    t = ((v - x0) * 65536) / (x1 - x0);
                    return h0 + floor_div((h1 - h0) * t + 32768, 65536);
                end
            end
            if (v < bp_x[c][0]) return bp_h[c][0];
            return bp_h[c][n-1];
        endfunction

        function void note(item_t it);
            longint hi, div, tot, w, fine, rnd;
            if (it.opcode == OP_LOAD) begin
                if (it.curve > CURVE_EROS) return;
                bp_x[it.curve][it.index] = longint'(it.noise);
                bp_h[it.curve][it.index] = longint'(it.height);
                bp_written[it.curve][it.index] = 1;
                if (it.last) bp_count[it.curve] = it.index + 1;
                return;
            end
            hi = col < 9 ? 9 : (col > 1024 ? 1024 : col);
            hi -= 8;
            div = bws == 0 ? 1 : bws;
            tot = strength[0] + strength[1] + strength[2];
            if (tot == 0) begin
                fine = (sea * 65536) / div;
            end else begin
                w = curve_height(0, longint'(it.cont_v)) * strength[0]
                  + curve_height(1, longint'(it.peaks_v)) * strength[1]
                  + curve_height(2, longint'(it.eros_v)) * strength[2];
                fine = floor_div(w * 256, tot * div);
            end
            if (fine < 256) fine = 256;
            if (fine > hi * 256) fine = hi * 256;
            rnd = (fine + 128) / 256;
            if (rnd < 1) rnd = 1;
            if (rnd > hi) rnd = hi;
            owed_sh.push_back(int'(rnd));
            owed_fine.push_back(int'(fine));
        endfunction

        function void check(logic [SH_W-1:0] sh, logic [FINE_W-1:0] fine);
            int e_sh, e_fine;
            if (owed_sh.size() == 0) begin
                $display("%0t: unexpected result transfer sh=%0d fine=%0d", $time, sh, fine);
                errors++;
                return;
            end
            e_sh = owed_sh.pop_front();
            e_fine = owed_fine.pop_front();
            if (sh !== e_sh[SH_W-1:0]) begin
                $display("%0t: surface_height expected %0d actual %0d", $time, e_sh, sh);
                errors++;
            end
            if (fine !== e_fine[FINE_W-1:0]) begin
                $display("%0t: surface_height_fine expected %0d actual %0d",
                         $time, e_fine, fine);
                errors++;
            end
        endfunction

        function int pending();
            return owed_sh.size();
        endfunction
    endclass

    logic aclk, aresetn;
    logic cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic s_valid, s_ready, s_opcode, s_point_last;
    logic [1:0] s_curve_select;
    logic [3:0] s_point_index;
    logic signed [NOISE_W-1:0] s_point_noise, s_continental_value, s_peaks_value;
    logic signed [NOISE_W-1:0] s_erosion_value;
    logic signed [HEIGHT_W-1:0] s_point_height;
    logic m_valid, m_ready;
    logic [SH_W-1:0] m_surface_height;
    logic [FINE_W-1:0] m_surface_height_fine;

    height_scoreboard sb;
    bit calm;
    int quiet_cycles;

    spline_surface_height uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_curve_select(s_curve_select), .s_point_index(s_point_index),
        .s_point_last(s_point_last), .s_point_noise(s_point_noise),
        .s_point_height(s_point_height), .s_continental_value(s_continental_value),
        .s_peaks_value(s_peaks_value), .s_erosion_value(s_erosion_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_surface_height(m_surface_height), .m_surface_height_fine(m_surface_height_fine)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // result side: random backpressure, checked at the rising edge
    always @(negedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check(m_surface_height, m_surface_height_fine);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("spline_surface_height_tb: errors");
            $finish;
        end
    end

    task automatic send(item_t it);
        @(negedge aclk);
        if (!calm && $urandom_range(99) < 36) begin
            s_valid = 0;
            repeat ($urandom_range(3, 1)) @(negedge aclk);
        end
        s_opcode = it.opcode; s_curve_select = it.curve; s_point_index = it.index;
        s_point_last = it.last; s_point_noise = it.noise; s_point_height = it.height;
        s_continental_value = it.cont_v; s_peaks_value = it.peaks_v;
        s_erosion_value = it.eros_v;
        s_valid = 1;
        do @(posedge aclk); while (!s_ready);
        sb.note(it);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(negedge aclk);
        cfg_wen = 1; cfg_index = idx; cfg_wdata = d;
        @(negedge aclk);
        cfg_wen = 0;
        sb.set_reg(idx, d);
    endtask

    task automatic write_all(int s0, int s1, int s2, int sea, int bws, int col);
        write_reg(CFG_STR_CONT, s0[15:0]);
        write_reg(CFG_STR_PEAKS, s1[15:0]);
        write_reg(CFG_STR_EROS, s2[15:0]);
        write_reg(CFG_SEA, sea[15:0]);
        write_reg(CFG_BWS, bws[15:0]);
        write_reg(CFG_COL, col[15:0]);
    endtask

    function automatic item_t blank();
        item_t it;
        it.opcode = OP_QUERY; it.curve = CURVE_CONT; it.index = 0; it.last = 0;
        it.noise = 0; it.height = 0; it.cont_v = 0; it.peaks_v = 0; it.eros_v = 0;
        return it;
    endfunction

    task automatic load_point(logic [1:0] c, int idx, bit last, int x, int h);
        item_t it;
        it = blank();
        it.opcode = OP_LOAD; it.curve = c; it.index = idx[3:0]; it.last = last;
        it.noise = x[15:0]; it.height = h[23:0];
        send(it);
    endtask

    task automatic query(int a, int b, int c);
        item_t it;
        it = blank();
        it.cont_v = a[15:0]; it.peaks_v = b[15:0]; it.eros_v = c[15:0];
        send(it);
    endtask

    // whole table, usually ascending in noise, sometimes with repeated points
    task automatic load_curve(logic [1:0] c, int n, bit ordered);
        int xs[MAX_POINTS];
        int tmp;
        for (int i = 0; i < n; i++) begin
            xs[i] = $urandom_range(3) == 0 ? $signed($urandom_range(65535) - 32768)
                                           : $signed($urandom_range(8191) - 4096);
            if (i > 0 && $urandom_range(7) == 0) xs[i] = xs[i-1];
        end
        if (ordered)
            for (int i = 1; i < n; i++)
                for (int j = i; j > 0 && xs[j-1] > xs[j]; j--) begin
                    tmp = xs[j]; xs[j] = xs[j-1]; xs[j-1] = tmp;
                end
        for (int i = 0; i < n; i++)
            load_point(c, i, i == n - 1, xs[i],
                       $urandom_range(3) == 0 ? int'($urandom) : $urandom_range(131071) - 65536);
    endtask

    function automatic int pick_value(int c);
        int n;
        n = sb.bp_count[c];
        if (n > 0 && $urandom_range(99) < 60)
            return int'(sb.bp_x[c][$urandom_range(n - 1)]) + $urandom_range(64) - 32;
        return $urandom_range(65535) - 32768;
    endfunction

    task automatic random_phase(int items);
        int done, r, c, idx;
        bit ok;
        done = 0;
        while (done < items) begin
            r = $urandom_range(99);
            if (r < 12) begin
                c = $urandom_range(2);
                idx = $urandom_range(3) == 0 ? $urandom_range(16, 1) : $urandom_range(5, 1);
                load_curve(c[1:0], idx, $urandom_range(4) != 0);
                done += idx;
            end else if (r < 20) begin
                // stray load: any curve, last only over a fully written prefix
                c = $urandom_range(3);
                idx = $urandom_range(15);
                ok = $urandom_range(1);
                if (c < 3) for (int i = 0; i < idx; i++) if (!sb.bp_written[c][i]) ok = 0;
                if (c < 3 && !sb.bp_written[c][idx] && idx > 0) ok = 0;
                load_point(c[1:0], idx, ok, $urandom_range(65535), int'($urandom));
                done++;
            end else begin
                query(pick_value(0), pick_value(1), pick_value(2));
                done++;
            end
        end
        drain();
    endtask

    initial begin
        sb = new();
        calm = 0;
        quiet_cycles = 0;
        aresetn = 0; cfg_wen = 0; cfg_index = 0; cfg_wdata = 0;
        s_valid = 0; s_opcode = 0; s_curve_select = 0; s_point_index = 0;
        s_point_last = 0; s_point_noise = 0; s_point_height = 0;
        s_continental_value = 0; s_peaks_value = 0; s_erosion_value = 0;
        m_ready = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // empty tables give zero height, floor clamp
        query(0, 32767, -32768);
        // extremes, ignored curve select, unmarked load
        load_point(CURVE_CONT, 0, 0, -32768, -8388608);
        load_point(CURVE_CONT, 1, 1, 32767, 8388607);
        load_point(2'd3, 0, 1, 0, 0);
        load_point(CURVE_PEAKS, 0, 0, 10, 2560);
        load_point(CURVE_PEAKS, 1, 0, -5, 5120);
        load_point(CURVE_PEAKS, 2, 0, -5, 7680);
        load_point(CURVE_PEAKS, 3, 1, 300, 100000);
        load_point(CURVE_EROS, 0, 1, 4096, 65536);
        query(-32768, -5, 0);
        query(32767, -100, 4096);
        query(0, 200, 32767);
        query(1, 10, -32768);
        query(-1, 400, 4095);
        drain();
        write_all(0, 0, 0, 4095, 0, 0);
        query(0, 0, 0);
        drain();
        write_all(65535, 65535, 65535, 0, 1, 2047);
        query(32767, 300, 4096);
        query(-32768, 0, 0);
        drain();
        write_reg(CFG_UNUSED_LO, 16'hFFFF);
        write_reg(CFG_UNUSED_HI, 16'h0000);
        query(100, 100, 100);
        drain();

        write_all(256, 256, 256, 64, 256, 256);
        random_phase(260);
        write_all(0, 0, 0, $urandom_range(4095), $urandom_range(65535), $urandom_range(2047));
        random_phase(150);
        write_all(65535, 0, 1, 0, 65535, 1024);
        calm = 1;
        random_phase(250);
        calm = 0;
        write_all($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(4095), $urandom_range(65535, 1), $urandom_range(1024, 9));
        random_phase(260);
        write_all($urandom_range(512), $urandom_range(512), $urandom_range(512),
                  4095, 1, 9);
        random_phase(200);
        write_all($urandom_range(1024), $urandom_range(1024), $urandom_range(1024),
                  $urandom_range(4095), $urandom_range(64, 1), 8);
        random_phase(200);
        write_all($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(4095), 0, $urandom_range(2047));
        random_phase(210);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("spline_surface_height_tb: clean");
        end else begin
            $display("spline_surface_height_tb: errors");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+src
src/ssh_pkg.sv
src/ssh_lane.sv
src/ssh_combine.sv
src/spline_surface_height.sv
verif/spline_surface_height_tb.sv
